>>> hw/rtl/ccm_pkg.sv
`default_nettype none

package ccm_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOTAL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE  = 3'd4;

  localparam int CFG_DATA_W = 32;
  localparam int POS_COL_W  = 12;
  localparam int POS_ROW_W  = 16;
  localparam int MARK_W     = 2;

  // Result mark codes.
  localparam logic [MARK_W-1:0] MARK_NONE   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_EDGE   = 2'd1;
  localparam logic [MARK_W-1:0] MARK_NODATA = 2'd2;
  localparam logic [MARK_W-1:0] MARK_UNUSED = 2'd3;

  typedef struct packed {
    logic [POS_COL_W-1:0] col;
    logic [POS_ROW_W-1:0] row;
    logic [MARK_W-1:0]    mark;
    logic                 done;
  } ccm_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/contour_crossing_marker.sv
`default_nettype none

// Contour crossing marker. Elevation pixels enter in raster order and each one
// is given a band level floor(elevation / band_interval). One row of levels is
// kept in a single-port-write, registered-read line memory, so the result of a
// pixel leaves when the pixel below it arrives; the last row is finished as it
// arrives and its final result carries image_done. Each pixel passes through a
// restoring divider, which produces one quotient bit per cycle, and then hands
// its zero to three results to the output register one at a time, held back
// while the output register is not free. The line memory needs no clearing
// pass after reset. The next pixel is taken while the last result of the
// previous one still waits in the output register.
module contour_crossing_marker #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int ELEV_WIDTH     = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ccm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ccm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 pixel_valid,
  output logic                                 pixel_ready,
  input  logic signed [ELEV_WIDTH-1:0]         elevation,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [ccm_pkg::POS_COL_W-1:0]        pixel_col,
  output logic [ccm_pkg::POS_ROW_W-1:0]        pixel_row,
  output logic [ccm_pkg::MARK_W-1:0]           mark,
  output logic                                 image_done
);
  import ccm_pkg::*;

  localparam int COL_W = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int LEN_W = (COL_W + 1 > 13) ? COL_W + 1 : 13;
  localparam int CNT_W = $clog2(ELEV_WIDTH);
  localparam int CMP_W = (ELEV_WIDTH > 32) ? ELEV_WIDTH : 32;

  typedef struct packed {
    logic                         nodata;
    logic signed [ELEV_WIDTH-1:0] level;
  } cell_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic logic [MARK_W-1:0] mark_of(input cell_t self, input logic has_r,
                                                input cell_t rgt, input logic has_b,
                                                input cell_t bot);
    logic [MARK_W-1:0] m;
    m = MARK_NONE;
    if (self.nodata) begin
      m = MARK_NODATA;
    end else if (has_r && !rgt.nodata && rgt.level != self.level) begin
      m = MARK_EDGE;
    end else if (has_b && !bot.nodata && bot.level != self.level) begin
      m = MARK_EDGE;
    end
    return m;
  endfunction

  function automatic logic [POS_COL_W-1:0] col_out(input logic [COL_W-1:0] c);
    logic [COL_W+POS_COL_W-1:0] x;
    x = {{POS_COL_W{1'b0}}, c};
    return x[POS_COL_W-1:0];
  endfunction

  // Configuration registers.
  logic [12:0] row_length;
  logic [15:0] row_total;
  logic [30:0] band_interval;
  logic        nodata_enable;
  logic [31:0] nodata_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length    <= 13'd4096;
      row_total     <= 16'd1;
      band_interval <= 31'd25600;
      nodata_enable <= 1'b0;
      nodata_value  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_LENGTH:    row_length    <= cfg_data[12:0];
        CFG_ROW_TOTAL:     row_total     <= cfg_data[15:0];
        CFG_BAND_INTERVAL: band_interval <= cfg_data[30:0];
        CFG_NODATA_ENABLE: nodata_enable <= cfg_data[0];
        CFG_NODATA_VALUE:  nodata_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control and position state.
  state_t                 state;
  logic [COL_W-1:0]       col_count;
  logic [POS_ROW_W-1:0]   row_count;
  cell_t                  prior_pixel;
  logic [CNT_W-1:0]       cnt;
  logic [2:0]             pend;
  logic                   last_col_q;
  logic                   last_row_q;
  logic                   nodata_q;
  logic                   neg_q;
  logic [ELEV_WIDTH-1:0]  quo;
  logic [30:0]            rem;
  cell_t                  above;
  cell_t                  right;
  ccm_result_t            res_buf [3];
  ccm_result_t            res_q;

  // Line memory of the previous row.
  cell_t            line_mem [MAX_ROW_LENGTH];
  logic [COL_W-1:0] rd_addr;
  cell_t            rd_data;
  logic             wr_en;
  cell_t            cur;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[col_count] <= cur;
    end
    rd_data <= line_mem[rd_addr];
  end

  // The column above is fetched first, then its right neighbor.
  assign rd_addr = (cnt == '0) ? col_count : col_count + COL_W'(1);

  // Geometry at the time a pixel is taken.
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len_eff;
  logic [15:0]      rows_eff;
  logic             last_col_w;
  logic             last_row_w;

  always_comb begin
    len_raw = LEN_W'(row_length);
    if (row_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > LEN_W'(MAX_ROW_LENGTH)) begin
      len_eff = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len_eff = len_raw;
    end
    rows_eff   = (row_total == '0) ? 16'd1 : row_total;
    last_col_w = (LEN_W'(col_count) + LEN_W'(1)) >= len_eff;
    last_row_w = row_count >= (rows_eff - 16'd1);
  end

  // Divider inputs.
  logic [ELEV_WIDTH-1:0]   elev_u;
  logic [ELEV_WIDTH-1:0]   elev_mag;
  logic signed [CMP_W-1:0] elev_x;
  logic signed [CMP_W-1:0] nodata_x;
  logic [30:0]             ival;
  logic [31:0]             trial;
  logic [31:0]             ival_x;
  logic                    take;

  always_comb begin
    elev_u   = elevation;
    elev_mag = elev_u[ELEV_WIDTH-1] ? (~elev_u + ELEV_WIDTH'(1)) : elev_u;
    elev_x   = CMP_W'(elevation);
    nodata_x = CMP_W'(signed'(nodata_value));
    ival     = (band_interval == '0) ? 31'd1 : band_interval;
    ival_x   = {1'b0, ival};
    trial    = {rem, quo[ELEV_WIDTH-1]};
    take     = trial >= ival_x;
  end

  // Level with the quotient rounded toward minus infinity.
  logic [ELEV_WIDTH-1:0] lvl_u;
  logic                  slot_free;

  always_comb begin
    if (!neg_q) begin
      lvl_u = quo;
    end else if (rem != '0) begin
      lvl_u = ~quo;
    end else begin
      lvl_u = ~quo + ELEV_WIDTH'(1);
    end
    cur.nodata = nodata_q;
    cur.level  = nodata_q ? '0 : signed'(lvl_u);
    wr_en      = (state == ST_FIN);
    slot_free  = !result_valid || result_ready;
  end

  assign pixel_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      col_count    <= '0;
      row_count    <= '0;
      prior_pixel  <= '0;
      pend         <= '0;
      result_valid <= 1'b0;
    end else begin
      // While sending, the output stage below decides valid on its own.
      if (result_valid && result_ready && (state != ST_EMIT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pixel_valid) begin
            cnt        <= '0;
            quo        <= elev_mag;
            rem        <= '0;
            neg_q      <= elev_u[ELEV_WIDTH-1];
            nodata_q   <= nodata_enable && (elev_x == nodata_x);
            last_col_q <= last_col_w;
            last_row_q <= last_row_w;
            state      <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo <= {quo[ELEV_WIDTH-2:0], take};
          rem <= take ? 31'(trial - ival_x) : trial[30:0];
          if (cnt == CNT_W'(1)) begin
            above <= rd_data;
          end
          if (cnt == CNT_W'(2)) begin
            right <= rd_data;
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(ELEV_WIDTH - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_buf[0] <= '{col: col_out(col_count), row: row_count - 16'd1,
                          mark: mark_of(above, !last_col_q, right, 1'b1, cur),
                          done: 1'b0};
          res_buf[1] <= '{col: col_out(col_count - COL_W'(1)), row: row_count,
                          mark: mark_of(prior_pixel, 1'b1, cur, 1'b0, cur),
                          done: 1'b0};
          res_buf[2] <= '{col: col_out(col_count), row: row_count,
                          mark: cur.nodata ? MARK_NODATA : MARK_NONE,
                          done: 1'b1};
          pend[0] <= (row_count != '0);
          pend[1] <= last_row_q && (col_count != '0);
          pend[2] <= last_row_q && last_col_q;
          prior_pixel <= cur;
          if (last_col_q) begin
            col_count <= '0;
            row_count <= last_row_q ? '0 : row_count + 16'd1;
          end else begin
            col_count <= col_count + COL_W'(1);
          end
          if ((row_count != '0) ||
              (last_row_q && ((col_count != '0) || last_col_q))) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            priority if (pend[0]) begin
              res_q <= res_buf[0];
              pend  <= {pend[2:1], 1'b0};
              if (pend[2:1] == '0) state <= ST_IDLE;
            end else if (pend[1]) begin
              res_q <= res_buf[1];
              pend  <= {pend[2], 2'b00};
              if (!pend[2]) state <= ST_IDLE;
            end else begin
              res_q <= res_buf[2];
              pend  <= '0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pixel_col  = res_q.col;
  assign pixel_row  = res_q.row;
  assign mark       = res_q.mark;
  assign image_done = res_q.done;

  // A pixel with no result must not leave the sequencer waiting on the output.
  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> pend != '0)
    else $error("output sequencer entered with nothing to send");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> pend == '0)
    else $error("pixel taken while results are still pending");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> state == ST_DIV && cnt == '0)
    else $error("divider not started on a taken pixel");

  // The final result has no neighbors, so it can never be a crossing.
  a_done_not_edge: assert property (@(posedge clk) disable iff (rst)
    result_valid && image_done |-> mark != MARK_EDGE)
    else $error("final result marked as a crossing");

  a_mark_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> mark != MARK_UNUSED)
    else $error("undefined mark code on the output");

endmodule

`default_nettype wire
